[hw/rtl/quadrature_encoder_with_button_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature encoder with button block
// Shared concurrent assertion forms, all reset-qualified.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_WITH_BUTTON_TOP_DEFINES_SVH
`define QUADRATURE_ENCODER_WITH_BUTTON_TOP_DEFINES_SVH

// Same-cycle implication
`define QEB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QEB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qeb_pkg.sv]
// ----------------------------------------------------------------------------
// qeb_pkg
// Types, constants and the quadrature transition table for the encoder block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qeb_pkg;

  localparam int PENDING_BITS_DEF = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_STEP_LATCH     = 2'd0;
  localparam cfg_idx_t CFG_MAX_STEPS      = 2'd1;
  localparam cfg_idx_t CFG_DIR_INVERT     = 2'd2;
  localparam cfg_idx_t CFG_DEBOUNCE_POLLS = 2'd3;

  localparam logic [2:0] STEP_LATCH_RST     = 3'd2;
  localparam logic [3:0] MAX_STEPS_RST      = 4'd1;
  localparam logic       DIR_INVERT_RST     = 1'b0;
  localparam logic [3:0] DEBOUNCE_POLLS_RST = 4'd2;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_POLL   = 1'b1
  } op_t;

  typedef struct packed {
    logic [2:0] step_latch;
    logic [3:0] max_steps;
    logic       dir_invert;
    logic [3:0] debounce_polls;
  } cfg_t;

  typedef struct packed {
    logic       has_event;
    logic       btn_press;
    logic signed [4:0] steps;
  } result_t;

  // Gray-code transition: {prev, cur} -> +1 / -1 / 0
  function automatic logic signed [1:0] quad_delta(input logic [1:0] prev,
                                                   input logic [1:0] cur);
    logic signed [1:0] d;
    unique case ({prev, cur})
      4'b0001, 4'b0111, 4'b1110, 4'b1000: d = 2'sd1;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: d = -2'sd1;
      default:                            d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/qeb_core.sv]
// ----------------------------------------------------------------------------
// qeb_core
// Encoder state: transition accumulator, pending step count and button
// debounce. Updates on each fired item; poll result is combinational.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quadrature_encoder_with_button_top_defines.svh"

module qeb_core #(
  parameter int PENDING_BITS = qeb_pkg::PENDING_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  qeb_pkg::op_t      op,
  input  logic [1:0]        ab_level,
  input  logic              button_level,
  input  qeb_pkg::cfg_t     cfg,
  output qeb_pkg::result_t  res
);

  localparam int PX = PENDING_BITS + 1;
  localparam logic signed [PENDING_BITS-1:0] PEND_MAX =
    {1'b0, {(PENDING_BITS-1){1'b1}}};
  localparam logic signed [PENDING_BITS-1:0] PEND_MIN_SAT =
    {1'b1, {(PENDING_BITS-2){1'b0}}, 1'b1};
  localparam logic signed [PENDING_BITS-1:0] PEND_MIN_RAW =
    {1'b1, {(PENDING_BITS-1){1'b0}}};

  logic [1:0]                      last_ab;
  logic signed [3:0]               transition_sum;
  logic signed [PENDING_BITS-1:0]  pending;
  logic                            raw_button;
  logic                            stable_button;
  logic [3:0]                      stable_poll_count;

  logic signed [1:0]               delta;
  logic [2:0]                      latch;
  logic signed [4:0]               latch_s;
  logic signed [4:0]               sum_ext;
  logic signed [4:0]               sum_adj;
  logic signed [3:0]               transition_sum_next;
  logic signed [1:0]               dir;
  logic signed [PENDING_BITS-1:0]  pend_sample;
  logic signed [PENDING_BITS-1:0]  pend_poll;
  logic signed [PENDING_BITS-1:0]  pending_next;
  logic signed [PX-1:0]            pend_x;
  logic signed [PX-1:0]            lim_x;
  logic signed [PX-1:0]            pend_dec;
  logic signed [PX-1:0]            pend_inc;
  logic signed [4:0]               steps;
  logic [4:0]                      steps_mag;
  logic                            raw_button_next;
  logic [3:0]                      stable_poll_count_next;
  logic                            stable_button_next;
  logic                            pressed;

  // ---- A/B sample path
  always_comb begin
    delta   = qeb_pkg::quad_delta(last_ab, ab_level);
    latch   = (cfg.step_latch == 3'd0) ? 3'd1 : cfg.step_latch;
    latch_s = signed'({2'b00, latch});
    sum_ext = signed'({transition_sum[3], transition_sum}) +
              signed'({{3{delta[1]}}, delta});
    sum_adj = sum_ext;
    dir     = 2'sd0;
    if (delta != 2'sd0) begin
      if (sum_ext >= latch_s) begin
        sum_adj = sum_ext - latch_s;
        dir     = 2'sd1;
      end else if (sum_ext <= -latch_s) begin
        sum_adj = sum_ext + latch_s;
        dir     = -2'sd1;
      end
    end
    transition_sum_next = sum_adj[3:0];
    if (cfg.dir_invert) begin
      dir = -dir;
    end
    pend_sample = pending;
    if (dir == 2'sd1 && pending != PEND_MAX) begin
      pend_sample = pending + PENDING_BITS'(1);
    end else if (dir == -2'sd1 && pending != PEND_MIN_SAT) begin
      pend_sample = pending - PENDING_BITS'(1);
    end
  end

  // ---- poll path: step release
  always_comb begin
    pend_x   = signed'({pending[PENDING_BITS-1], pending});
    lim_x    = signed'({{(PX-4){1'b0}}, cfg.max_steps});
    pend_dec = pend_x - lim_x;
    pend_inc = pend_x + lim_x;
    priority if (pend_x > lim_x) begin
      steps     = signed'({1'b0, cfg.max_steps});
      pend_poll = pend_dec[PENDING_BITS-1:0];
    end else if (pend_x < -lim_x) begin
      steps     = -signed'({1'b0, cfg.max_steps});
      pend_poll = pend_inc[PENDING_BITS-1:0];
    end else begin
      steps     = pend_x[4:0];
      pend_poll = '0;
    end
    steps_mag = steps[4] ? 5'(-steps) : 5'(steps);
  end

  // ---- poll path: button debounce
  // A press is reported in the poll that finds it, so no pending flag is kept.
  always_comb begin
    raw_button_next        = raw_button;
    stable_poll_count_next = stable_poll_count;
    if (button_level == raw_button) begin
      if (stable_poll_count < cfg.debounce_polls) begin
        stable_poll_count_next = stable_poll_count + 4'd1;
      end
    end else begin
      raw_button_next        = button_level;
      stable_poll_count_next = 4'd0;
    end
    stable_button_next = stable_button;
    pressed            = 1'b0;
    if (stable_poll_count_next >= cfg.debounce_polls &&
        stable_button != button_level) begin
      stable_button_next = button_level;
      pressed            = ~button_level;
    end
  end

  assign pending_next       = (op == qeb_pkg::OP_POLL) ? pend_poll : pend_sample;
  assign res.steps          = steps;
  assign res.btn_press      = pressed;
  assign res.has_event      = (steps != 5'sd0) || pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ab           <= 2'b11;
      transition_sum    <= '0;
      pending           <= '0;
      raw_button        <= 1'b1;
      stable_button     <= 1'b1;
      stable_poll_count <= '0;
    end else if (fire) begin
      pending <= pending_next;
      if (op == qeb_pkg::OP_SAMPLE) begin
        last_ab        <= ab_level;
        transition_sum <= transition_sum_next;
      end else begin
        raw_button        <= raw_button_next;
        stable_button     <= stable_button_next;
        stable_poll_count <= stable_poll_count_next;
      end
    end
  end

  `QEB_ASSERT_IMPL(a_pend_sym, clk, rst, 1'b1, pending != PEND_MIN_RAW, "pending count out of range")
  `QEB_ASSERT_IMPL(a_sum_range, clk, rst, 1'b1, transition_sum != -4'sd8, "accumulator overflow")
  `QEB_ASSERT_IMPL(a_steps_lim, clk, rst, fire && op == qeb_pkg::OP_POLL, steps_mag <= {1'b0, cfg.max_steps}, "poll released too many steps")

endmodule

[hw/rtl/quadrature_encoder_with_button_top.sv]
// ----------------------------------------------------------------------------
// quadrature_encoder_with_button_top
// Rotary quadrature decoder with detent latching and a debounced push button.
// ----------------------------------------------------------------------------
//  channel   | signals                 | carries
//  ----------+-------------------------+-------------------------------------
//  s_axis    | tvalid tready tdata tuser | sample (tuser=0) or poll (tuser=1)
//  m_axis    | tvalid tready tdata     | one result per poll, none per sample
//  cfg       | cfg_we cfg_addr cfg_data | register write, no read-back
//
//  One item per cycle, except while a poll waits. An item is captured in the
//  input register and processed from there; a poll result is loaded into the
//  result register at the end of the cycle in which the poll is processed.
//  Samples never stall. A poll waits in the input register only while the
//  result register holds a result that m_axis_tready does not take.
//  Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quadrature_encoder_with_button_top_defines.svh"

module quadrature_encoder_with_button_top #(
  parameter int PENDING_BITS = qeb_pkg::PENDING_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [1:0] ab_level, [2] button_level
  input  logic [0:0]                     s_axis_tuser,  // [0] op
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [4:0] steps, [5] btn_press,
                                                        // [6] has_event
  input  logic                           cfg_we,
  input  logic [qeb_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [qeb_pkg::CFG_DATA_W-1:0] cfg_data
);

  qeb_pkg::cfg_t    cfg;
  logic             in_valid;
  qeb_pkg::op_t     in_op;
  logic [1:0]       in_ab;
  logic             in_btn;
  logic             out_valid;
  qeb_pkg::result_t out_res;
  qeb_pkg::result_t core_res;
  logic             fire;
  logic             poll_fire;

  assign fire          = in_valid &&
                         (in_op == qeb_pkg::OP_SAMPLE || !out_valid || m_axis_tready);
  assign poll_fire     = fire && in_op == qeb_pkg::OP_POLL;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_latch     <= qeb_pkg::STEP_LATCH_RST;
      cfg.max_steps      <= qeb_pkg::MAX_STEPS_RST;
      cfg.dir_invert     <= qeb_pkg::DIR_INVERT_RST;
      cfg.debounce_polls <= qeb_pkg::DEBOUNCE_POLLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        qeb_pkg::CFG_STEP_LATCH:     cfg.step_latch     <= cfg_data[2:0];
        qeb_pkg::CFG_MAX_STEPS:      cfg.max_steps      <= cfg_data[3:0];
        qeb_pkg::CFG_DIR_INVERT:     cfg.dir_invert     <= cfg_data[0];
        qeb_pkg::CFG_DEBOUNCE_POLLS: cfg.debounce_polls <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_op  <= qeb_pkg::op_t'(s_axis_tuser[0]);
      in_ab  <= s_axis_tdata[1:0];
      in_btn <= s_axis_tdata[2];
    end
  end

  qeb_core #(
    .PENDING_BITS (PENDING_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .op           (in_op),
    .ab_level     (in_ab),
    .button_level (in_btn),
    .cfg          (cfg),
    .res          (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (poll_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (poll_fire) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.has_event, out_res.btn_press, out_res.steps};

  `QEB_ASSERT_NEXT(a_res_from_poll, clk, rst, !out_valid && !poll_fire, !out_valid, "result without a poll")
  `QEB_ASSERT_NEXT(a_poll_held, clk, rst, in_valid && in_op == qeb_pkg::OP_POLL && !fire, in_valid && in_op == qeb_pkg::OP_POLL, "stalled poll dropped")
  `QEB_ASSERT_NEXT(a_res_held, clk, rst, out_valid && !m_axis_tready, out_valid && $stable(m_axis_tdata), "stalled result changed")

endmodule

[tb/qeb_check.sv]
// ----------------------------------------------------------------------------
// qeb_check
// Watches the item, result and register-write ports of the encoder block,
// tracks rotation, pending detents and the debounced button on its own, and
// compares every poll result field by field with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qeb_check #(
  parameter int PENDING_BITS = qeb_pkg::PENDING_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [1:0] ab_level, [2] button_level
  input  logic [0:0]                     s_axis_tuser,  // [0] op
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [7:0]                     m_axis_tdata,  // [4:0] steps, [5] btn_press,
                                                        // [6] has_event
  input  logic                           cfg_we,
  input  logic [qeb_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [qeb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             reports_due
);

  localparam longint PEND_MAX = (64'sd1 <<< (PENDING_BITS - 1)) - 1;

  qeb_pkg::cfg_t    cfg;
  logic [1:0]       last_ab;
  int               tsum;
  longint           pend;
  logic             raw_btn;
  logic             stable_btn;
  int               hold_cnt;
  qeb_pkg::result_t poll_reports[$];
  int               errors = 0;

  // Clockwise Gray order is 11 -> 10 -> 00 -> 01 -> 11
  function automatic logic [1:0] cw_after(input logic [1:0] ab);
    case (ab)
      2'b11:   return 2'b10;
      2'b10:   return 2'b00;
      2'b00:   return 2'b01;
      default: return 2'b11;
    endcase
  endfunction

  function automatic int gray_dir(input logic [1:0] prev, input logic [1:0] cur);
    if (cur == cw_after(prev)) return 1;
    if (prev == cw_after(cur)) return -1;
    return 0;
  endfunction

  task automatic count_detent(input int dir);
    pend = pend + dir;
    if (pend > PEND_MAX) pend = PEND_MAX;
    if (pend < -PEND_MAX) pend = -PEND_MAX;
  endtask

  task automatic take_sample(input logic [1:0] ab);
    int d;
    int lat;
    int sgn;
    d   = gray_dir(last_ab, ab);
    lat = (cfg.step_latch == 3'd0) ? 1 : int'(cfg.step_latch);
    sgn = cfg.dir_invert ? -1 : 1;
    if (d != 0) begin
      tsum = tsum + d;
      if (tsum >= lat) begin
        count_detent(sgn);
        tsum = tsum - lat;
      end else if (tsum <= -lat) begin
        count_detent(-sgn);
        tsum = tsum + lat;
      end
    end
    last_ab = ab;
  endtask

  task automatic take_poll(input logic btn);
    longint           lim;
    longint           st;
    logic             pressed;
    qeb_pkg::result_t want;
    lim     = longint'(cfg.max_steps);
    pressed = 1'b0;
    if (pend > lim) begin
      st   = lim;
      pend = pend - lim;
    end else if (pend < -lim) begin
      st   = -lim;
      pend = pend + lim;
    end else begin
      st   = pend;
      pend = 0;
    end
    if (btn == raw_btn) begin
      if (hold_cnt < int'(cfg.debounce_polls)) hold_cnt++;
    end else begin
      raw_btn  = btn;
      hold_cnt = 0;
    end
    // settled level changed; a fall to 0 is a press, reported right away
    if (hold_cnt >= int'(cfg.debounce_polls) && stable_btn != btn) begin
      stable_btn = btn;
      if (!btn) pressed = 1'b1;
    end
    want.steps     = st[4:0];
    want.btn_press = pressed;
    want.has_event = (st != 0) || pressed;
    poll_reports.push_back(want);
  endtask

  always @(posedge clk) begin : watch
    qeb_pkg::result_t got;
    qeb_pkg::result_t want;
    if (rst) begin
      cfg.step_latch     = qeb_pkg::STEP_LATCH_RST;
      cfg.max_steps      = qeb_pkg::MAX_STEPS_RST;
      cfg.dir_invert     = qeb_pkg::DIR_INVERT_RST;
      cfg.debounce_polls = qeb_pkg::DEBOUNCE_POLLS_RST;
      last_ab    = 2'b11;
      tsum       = 0;
      pend       = 0;
      raw_btn    = 1'b1;
      stable_btn = 1'b1;
      hold_cnt   = 0;
      poll_reports.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = qeb_pkg::result_t'(m_axis_tdata[6:0]);
        if (poll_reports.size() == 0) begin
          $display("%0t: result with no poll outstanding: expected none, got tdata %h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          want = poll_reports.pop_front();
          if (got.steps !== want.steps) begin
            $display("%0t: steps expected %0d, got %0d", $time,
                     $signed(want.steps), $signed(got.steps));
            errors++;
          end
          if (got.btn_press !== want.btn_press) begin
            $display("%0t: btn_press expected %b, got %b", $time,
                     want.btn_press, got.btn_press);
            errors++;
          end
          if (got.has_event !== want.has_event) begin
            $display("%0t: has_event expected %b, got %b", $time,
                     want.has_event, got.has_event);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          qeb_pkg::CFG_STEP_LATCH:     cfg.step_latch     = cfg_data[2:0];
          qeb_pkg::CFG_MAX_STEPS:      cfg.max_steps      = cfg_data[3:0];
          qeb_pkg::CFG_DIR_INVERT:     cfg.dir_invert     = cfg_data[0];
          qeb_pkg::CFG_DEBOUNCE_POLLS: cfg.debounce_polls = cfg_data[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (qeb_pkg::op_t'(s_axis_tuser[0]) == qeb_pkg::OP_POLL) take_poll(s_axis_tdata[2]);
        else take_sample(s_axis_tdata[1:0]);
      end
    end
    fail_count  <= errors;
    reports_due <= poll_reports.size();
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the quadrature encoder block with directed and random sample and
// poll items under several register settings, with random idling on both
// streams; the checker beside the block does prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 90;
  localparam int PHASES      = 6;

  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata  = '0;
  logic [0:0]                     s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;
  logic                           cfg_we        = 1'b0;
  qeb_pkg::cfg_idx_t              cfg_addr      = qeb_pkg::CFG_STEP_LATCH;
  logic [qeb_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

  bit calm     = 1'b0;  // no idling on either side while set
  bit button   = 1'b1;
  int gray_pos = 0;     // position in the cw Gray cycle, 0 is 11
  int cycles   = 0;
  int fail_count;
  int reports_due;

  always #6 clk = ~clk;

  quadrature_encoder_with_button_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  qeb_check u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .reports_due   (reports_due)
  );

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [1:0] gray_ab(input int pos);
    case (pos & 3)
      0:       return 2'b11;
      1:       return 2'b10;
      2:       return 2'b00;
      default: return 2'b01;
    endcase
  endfunction

  task automatic send_item(input qeb_pkg::op_t op, input logic [1:0] ab, input logic btn);
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, btn, ab};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // unused field of each op is random so that its bits toggle too
  task automatic poll(input logic btn);
    send_item(qeb_pkg::OP_POLL, 2'($urandom_range(3)), btn);
  endtask

  task automatic jump(input int pos);
    gray_pos = pos & 3;
    send_item(qeb_pkg::OP_SAMPLE, gray_ab(gray_pos), 1'($urandom_range(1)));
  endtask

  task automatic rotate(input int n, input bit ccw);
    repeat (n) jump(ccw ? gray_pos + 3 : gray_pos + 1);
  endtask

  // wait until every poll result is taken, plus the block's own latency
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] latch, input logic [3:0] max_steps,
                            input logic inv, input logic [3:0] deb);
    settle();
    cfg_we   <= 1'b1;
    cfg_addr <= qeb_pkg::CFG_STEP_LATCH;
    cfg_data <= {1'b0, latch};
    @(posedge clk);
    cfg_addr <= qeb_pkg::CFG_MAX_STEPS;
    cfg_data <= max_steps;
    @(posedge clk);
    cfg_addr <= qeb_pkg::CFG_DIR_INVERT;
    cfg_data <= {3'd0, inv};
    @(posedge clk);
    cfg_addr <= qeb_pkg::CFG_DEBOUNCE_POLLS;
    cfg_data <= deb;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n;
    int len;
    int pick;
    bit ccw;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: detents both ways, skipped and repeated states, press
    poll(1'b1);
    rotate(2, 1'b0);
    jump(0);
    jump(0);
    rotate(2, 1'b1);
    rotate(4, 1'b0);
    repeat (4) poll(1'b0);
    repeat (3) poll(1'b1);

    // latch 0 acts as 1, nothing released, inverted, immediate debounce
    set_config(3'd0, 4'd0, 1'b1, 4'd0);
    rotate(2, 1'b0);
    poll(1'b0);
    poll(1'b1);
    rotate(3, 1'b1);

    // latch above four, longest debounce, then debounce lowered under the count
    set_config(3'd7, 4'd15, 1'b0, 4'd15);
    rotate(9, 1'b1);
    repeat (17) poll(1'b0);
    set_config(3'd7, 4'd15, 1'b0, 4'd4);
    repeat (2) poll(1'b0);
    repeat (6) poll(1'b1);

    ccw = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(3'($urandom_range(7)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                 4'($urandom_range(15)));
      calm = (ph == 2);
      n = 0;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          if ($urandom_range(99) < 30) ccw = !ccw;
          len = $urandom_range(12, 1);
          rotate(len, ccw);
          n += len;
        end else if (pick < 62) begin
          jump($urandom_range(3));
          n++;
        end else begin
          len = $urandom_range(4, 1);
          repeat (len) begin
            if ($urandom_range(99) < 10) button = !button;
            // occasional one-poll glitch against the held level
            if ($urandom_range(99) < 5) poll(!button);
            else poll(button);
          end
          n += len;
        end
      end
    end
    calm = 1'b0;

    settle();
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/qeb_pkg.sv
hw/rtl/qeb_core.sv
hw/rtl/quadrature_encoder_with_button_top.sv
tb/qeb_check.sv
tb/testbench.sv
